// ----- rtl/paft_pkg.sv -----
// shared types and constants for the paced advert forward table
package paft_pkg;

  localparam int TABLE_SLOTS_DEF = 16;
  localparam int PAYLOAD_MAX_DEF = 8;
  localparam logic [9:0] MS_PER_SEC = 10'd1000;

  localparam logic [1:0] REQ_ADVERT = 2'd0;
  localparam logic [1:0] REQ_FLUSH  = 2'd1;
  localparam logic [1:0] REQ_FORCE  = 2'd2;

  localparam logic [1:0] REG_CHANNEL_READY = 2'd0;
  localparam logic [1:0] REG_MIN_GAP       = 2'd1;
  localparam logic [1:0] REG_INTERVAL      = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_COMMIT,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input word
    logic clr_scan;  // restart scan index
    logic step;      // advance scan index
    logic rd;        // read slot at chosen index
    logic commit;    // apply update
    logic emit;      // load output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic hit;
    logic need_scan;
  } sts_t;

endpackage

// ----- rtl/paft_ctrl.sv -----
// control state machine for the forward table
module paft_ctrl
  import paft_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.clr_scan = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts.need_scan || sts.hit || sts.scan_last) begin
          state_next = ST_READ;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        cmd.emit = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid = (state == ST_OUT);

  no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("input accepted while busy");
  emit_from_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> (state == ST_OUT))
    else $error("output not presented after commit");
  out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

// ----- rtl/paft_dp.sv -----
// slot table, scan index, statistics and result register
module paft_dp
  import paft_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  output sts_t sts,
  input  logic cfg_valid,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0] req_type,
  input  logic [47:0] dev_addr,
  input  logic signed [7:0] signal_level,
  input  logic [3:0] payload_len,
  input  logic [63:0] payload_bytes,
  input  logic [31:0] now_ms,
  input  logic pool_available,
  output logic advert_taken,
  output logic sent,
  output logic pool_failed,
  output logic [3:0] entry_index,
  output logic [47:0] out_addr,
  output logic signed [7:0] out_level,
  output logic [3:0] out_len,
  output logic [63:0] out_bytes,
  output logic [4:0] tracked_count,
  output logic [31:0] total_sent,
  output logic [31:0] failures
);

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  // configuration
  logic        channel_ready;
  logic [15:0] min_gap;
  logic [15:0] interval_secs;
  logic [31:0] interval_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_ready <= 1'b0;
      min_gap <= 16'd1000;
      interval_secs <= 16'd60;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CHANNEL_READY: channel_ready <= cfg_data[0];
        REG_MIN_GAP:       min_gap <= cfg_data[15:0];
        REG_INTERVAL:      interval_secs <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // registered so the multiply sits alone
  always_ff @(posedge clk) begin
    interval_ms <= 32'(interval_secs) * 32'(MS_PER_SEC);
  end

  // captured input word
  logic [1:0]  r_req;
  logic [47:0] r_addr;
  logic [7:0]  r_level;
  logic [3:0]  r_len;
  logic [63:0] r_bytes;
  logic [31:0] r_now;
  logic        r_pool;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_req <= req_type;
      r_addr <= dev_addr;
      r_level <= signal_level;
      r_len <= (payload_len > 4'(PAYLOAD_MAX)) ? 4'(PAYLOAD_MAX) : payload_len;
      r_bytes <= payload_bytes;
      r_now <= now_ms;
      r_pool <= pool_available;
    end
  end

  // slot state
  logic [TABLE_SLOTS-1:0] used, pending, fwd_once;
  logic [31:0] last_fwd [TABLE_SLOTS];
  logic [47:0] s_addr [TABLE_SLOTS];
  logic [7:0]  s_level [TABLE_SLOTS];
  logic [3:0]  s_len [TABLE_SLOTS];
  logic [63:0] s_bytes [TABLE_SLOTS];
  logic [31:0] last_send, sent_cnt, fail_cnt;
  logic [CW-1:0] used_cnt;

  // scan
  logic [IW-1:0] idx;
  logic          found;
  logic          free_seen;
  logic [IW-1:0] free_idx;
  logic          cand;
  logic          gap_ok;

  assign gap_ok = channel_ready && ((r_now - last_send) >= {16'd0, min_gap});

  // per-slot test on the current index; last_fwd read is a memory-style port
  always_comb begin
    cand = 1'b0;
    unique case (r_req)
      REQ_ADVERT: cand = used[idx] && (s_addr[idx] == r_addr);
      REQ_FLUSH:  cand = used[idx] && pending[idx] &&
                         (!fwd_once[idx] || ((r_now - last_fwd[idx]) >= interval_ms));
      default:    cand = 1'b0;
    endcase
  end

  assign sts.hit = cand;
  assign sts.scan_last = (idx == IW'(TABLE_SLOTS - 1));
  assign sts.need_scan = (r_req == REQ_ADVERT) || ((r_req == REQ_FLUSH) && gap_ok);

  always_ff @(posedge clk) begin
    if (cmd.clr_scan) begin
      idx <= '0;
      free_seen <= 1'b0;
      free_idx <= '0;
      found <= 1'b0;
    end else if (cmd.step) begin
      idx <= idx + 1'b1;
    end
    if (!cmd.clr_scan && !cmd.rd && !cmd.commit && !found) begin
      if (cand) found <= 1'b1;
      if (!used[idx] && !free_seen) begin
        free_seen <= 1'b1;
        free_idx <= idx;
      end
    end
  end

  // slot selected for the update
  logic [IW-1:0] sel;
  logic          sel_ok;
  logic [47:0]   rd_addr;
  logic [7:0]    rd_level;
  logic [3:0]    rd_len;
  logic [63:0]   rd_bytes;
  logic [63:0]   kept;

  assign sel = found ? idx : free_idx;
  assign sel_ok = (r_req == REQ_ADVERT) ? (found || free_seen)
                : ((r_req == REQ_FLUSH) && sts.need_scan && found);

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_addr <= s_addr[idx];
      rd_level <= s_level[idx];
      rd_len <= s_len[idx];
      rd_bytes <= s_bytes[idx];
    end
  end

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      kept[b*8 +: 8] = (4'(b) < r_len) ? r_bytes[b*8 +: 8] : 8'd0;
    end
  end

  logic is_adv, is_flush_hit, do_send;
  assign is_adv = (r_req == REQ_ADVERT) && sel_ok;
  assign is_flush_hit = (r_req == REQ_FLUSH) && sel_ok;
  assign do_send = is_flush_hit && r_pool;

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (is_adv) begin
        s_addr[sel] <= r_addr;
        s_level[sel] <= r_level;
        s_len[sel] <= r_len;
        s_bytes[sel] <= kept;
      end
      if (do_send) last_fwd[sel] <= r_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      pending <= '0;
      fwd_once <= '0;
      last_send <= '0;
      sent_cnt <= '0;
      fail_cnt <= '0;
      used_cnt <= '0;
    end else if (cmd.commit) begin
      if (is_adv) begin
        if (!used[sel]) used_cnt <= used_cnt + 1'b1;
        used[sel] <= 1'b1;
        pending[sel] <= 1'b1;
      end
      if (do_send) begin
        pending[sel] <= 1'b0;
        fwd_once[sel] <= 1'b1;
        last_send <= r_now;
        sent_cnt <= sent_cnt + 1'b1;
      end
      if (is_flush_hit && !r_pool) fail_cnt <= fail_cnt + 1'b1;
      if (r_req == REQ_FORCE) begin
        fwd_once <= '0;
        last_send <= '0;
      end
    end
  end

  // result register
  logic [CW-1:0] cnt_after;
  assign cnt_after = (is_adv && !used[sel]) ? used_cnt + 1'b1 : used_cnt;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      advert_taken <= is_adv;
      sent <= do_send;
      pool_failed <= is_flush_hit && !r_pool;
      entry_index <= is_flush_hit ? 4'(sel) : 4'd0;
      out_addr <= is_flush_hit ? rd_addr : 48'd0;
      out_level <= is_flush_hit ? rd_level : 8'd0;
      out_len <= is_flush_hit ? rd_len : 4'd0;
      out_bytes <= is_flush_hit ? rd_bytes : 64'd0;
      tracked_count <= 5'(cnt_after);
      total_sent <= do_send ? sent_cnt + 1'b1 : sent_cnt;
      failures <= (is_flush_hit && !r_pool) ? fail_cnt + 1'b1 : fail_cnt;
    end
  end

  count_matches: assert property (@(posedge clk) disable iff (rst)
    used_cnt == CW'($countones(used)))
    else $error("slot count out of step with used marks");
  pending_only_used: assert property (@(posedge clk) disable iff (rst)
    (pending & ~used) == '0)
    else $error("pending mark on free slot");
  send_sets_gap: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && do_send) |=> (last_send == $past(r_now)))
    else $error("send time not recorded");

endmodule

// ----- rtl/paced_advert_forward_table_top.sv -----
// top level of the paced advert forward table
//  channel | direction | handshake         | word
//  in      | in        | in_valid/in_stall | request fields
//  out     | out       | out_valid/out_stall | result fields
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
// an item passes the scan, read, commit and output states; the scan walks the slots
// the scan stops at the first matching slot; a flush that is not due skips the scan
// reset clears the FSM, config, marks and counters; slot payload is held uncleared
// the result stays in its register until out_stall is low
module paced_advert_forward_table_top
  import paft_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  parameter int PAYLOAD_MAX = PAYLOAD_MAX_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] req_type,
  input  logic [47:0] dev_addr,
  input  logic signed [7:0] signal_level,
  input  logic [3:0] payload_len,
  input  logic [63:0] payload_bytes,
  input  logic [31:0] now_ms,
  input  logic pool_available,
  output logic out_valid,
  input  logic out_stall,
  output logic advert_taken,
  output logic sent,
  output logic pool_failed,
  output logic [3:0] entry_index,
  output logic [47:0] out_addr,
  output logic signed [7:0] out_level,
  output logic [3:0] out_len,
  output logic [63:0] out_bytes,
  output logic [4:0] tracked_count,
  output logic [31:0] total_sent,
  output logic [31:0] failures,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  paft_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  paft_dp #(.TABLE_SLOTS(TABLE_SLOTS), .PAYLOAD_MAX(PAYLOAD_MAX)) u_dp (
    .clk, .rst, .cmd, .sts,
    .cfg_valid(cfg_valid && cfg_ready), .cfg_index, .cfg_data,
    .req_type, .dev_addr, .signal_level, .payload_len, .payload_bytes,
    .now_ms, .pool_available,
    .advert_taken, .sent, .pool_failed, .entry_index, .out_addr, .out_level,
    .out_len, .out_bytes, .tracked_count, .total_sent, .failures
  );

endmodule
